>>> rtl/mcbd_pkg.sv
// ----------------------------------------------------------------------------
// mcbd_pkg
// Shared types, constants and helper functions of the byte debouncer.
// ----------------------------------------------------------------------------
package mcbd_pkg;

  localparam int NUM_CHANNELS_DEF = 4;
  localparam int BITS_PER_CH      = 8;
  localparam int CNT_W            = 16;
  localparam int CH_PORT_W        = 2;
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CNT_W-1:0]       LIMIT_RESET    = 16'd10;
  localparam logic [BITS_PER_CH-1:0] DIP_MASK_RESET = 8'hFF;
  localparam logic [BITS_PER_CH-1:0] SENSOR_KEEP    = 8'hF0;
  localparam logic [CNT_W-1:0]       CNT_MAX        = 16'hFFFF;

  typedef enum logic [CH_PORT_W-1:0] {
    CH_DIP     = 2'd0,
    CH_ID      = 2'd1,
    CH_SENSOR  = 2'd2,
    CH_GENERAL = 2'd3
  } ch_code_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIP_LIMIT     = 3'd0,
    REG_ID_LIMIT      = 3'd1,
    REG_FRONT_LIMIT   = 3'd2,
    REG_SENSOR_LIMIT  = 3'd3,
    REG_GENERAL_LIMIT = 3'd4,
    REG_DIP_MASK      = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]       dip_limit;
    logic [CNT_W-1:0]       id_limit;
    logic [CNT_W-1:0]       front_limit;
    logic [CNT_W-1:0]       sensor_limit;
    logic [CNT_W-1:0]       general_limit;
    logic [BITS_PER_CH-1:0] dip_mask;
  } cfg_t;

  typedef struct packed {
    logic             en;
    logic             new_bit;
    logic             stable_bit;
    logic [CNT_W-1:0] limit;
  } lane_in_t;

  function automatic logic [CNT_W-1:0] limit_for(cfg_t cfg, ch_code_t ch, logic upper);
    logic [CNT_W-1:0] lim;
    unique case (ch)
      CH_DIP:     lim = cfg.dip_limit;
      CH_ID:      lim = cfg.id_limit;
      CH_SENSOR:  lim = upper ? cfg.sensor_limit : cfg.front_limit;
      CH_GENERAL: lim = cfg.general_limit;
      default:    lim = cfg.general_limit;
    endcase
    return lim;
  endfunction

  // port byte to active-high sample (ID passes uninverted), masked for DIP and sensor
  function automatic logic [BITS_PER_CH-1:0] shape_byte(cfg_t cfg, ch_code_t ch,
                                                         logic [BITS_PER_CH-1:0] raw);
    logic [BITS_PER_CH-1:0] b;
    b = (ch == CH_ID) ? raw : ~raw;
    if (ch == CH_DIP) begin
      b = b & cfg.dip_mask;
    end else if (ch == CH_SENSOR) begin
      b = b & SENSOR_KEEP;
    end
    return b;
  endfunction

endpackage

>>> rtl/multi_channel_byte_debouncer.sv
// ----------------------------------------------------------------------------
// multi_channel_byte_debouncer
// Per-bit counter debouncer for several 8-bit input ports, active-low but for ID.
//
// Input beat: channel and raw_byte, one poll tick of that channel. Output
// beat: changed and stable_byte, the channel's debounced byte after the tick.
// Every input beat yields exactly one output beat; a channel at or above
// NUM_CHANNELS gives changed = 0 and stable_byte = 0 and touches no state.
// Eight bit lanes update their counters in the accept cycle; the result is
// held in the output register in the cycle after the input beat is taken.
// Throughput is one beat per cycle while out_ready keeps the output moving;
// each lane's counter increment and limit compare are combinational.
// While an output beat waits for out_ready, in_ready is low; it rises in
// the cycle the output is taken, so a new beat can enter in that same cycle.
// Configuration: cfg_we writes cfg_wdata to the register at cfg_index in the
// same cycle; write only while the block is idle; indexes beyond the list are
// ignored.
// Reset (rst, synchronous) clears all counters and stable bytes, restores
// limits to 10 and the DIP mask to all ones, and empties the output register.
// ----------------------------------------------------------------------------
module multi_channel_byte_debouncer
  import mcbd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [CH_PORT_W-1:0]   channel,
  input  logic [BITS_PER_CH-1:0] raw_byte,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   changed,
  output logic [BITS_PER_CH-1:0] stable_byte
);

  localparam int CH_W = $clog2(NUM_CHANNELS);

  cfg_t                   cfg;
  logic [BITS_PER_CH-1:0] stable_q [NUM_CHANNELS];
  logic [CH_W-1:0]        ch_idx;
  logic                   ch_ok;
  logic                   acc;
  ch_code_t               ch_code;
  logic [BITS_PER_CH-1:0] new_byte;
  logic [BITS_PER_CH-1:0] cur_stable;
  logic [BITS_PER_CH-1:0] flips;
  logic [BITS_PER_CH-1:0] stable_next;
  lane_in_t               lane_in [BITS_PER_CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dip_limit     <= LIMIT_RESET;
      cfg.id_limit      <= LIMIT_RESET;
      cfg.front_limit   <= LIMIT_RESET;
      cfg.sensor_limit  <= LIMIT_RESET;
      cfg.general_limit <= LIMIT_RESET;
      cfg.dip_mask      <= DIP_MASK_RESET;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DIP_LIMIT:     cfg.dip_limit     <= cfg_wdata;
        REG_ID_LIMIT:      cfg.id_limit      <= cfg_wdata;
        REG_FRONT_LIMIT:   cfg.front_limit   <= cfg_wdata;
        REG_SENSOR_LIMIT:  cfg.sensor_limit  <= cfg_wdata;
        REG_GENERAL_LIMIT: cfg.general_limit <= cfg_wdata;
        REG_DIP_MASK:      cfg.dip_mask      <= cfg_wdata[BITS_PER_CH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    in_ready   = !out_valid || out_ready;
    acc        = in_valid && in_ready;
    ch_code    = ch_code_t'(channel);
    ch_idx     = CH_W'(channel);
    ch_ok      = (32'(channel) < NUM_CHANNELS);
    new_byte   = shape_byte(cfg, ch_code, raw_byte);
    cur_stable = ch_ok ? stable_q[ch_idx] : '0;
    for (int b = 0; b < BITS_PER_CH; b++) begin
      lane_in[b].en         = acc && ch_ok;
      lane_in[b].new_bit    = new_byte[b];
      lane_in[b].stable_bit = cur_stable[b];
      lane_in[b].limit      = limit_for(cfg, ch_code, (b >= BITS_PER_CH / 2));
    end
  end

  for (genvar g = 0; g < BITS_PER_CH; g++) begin : g_lane
    mcbd_lane #(
      .NUM_CHANNELS(NUM_CHANNELS)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .ch_idx (ch_idx),
      .lane_in(lane_in[g]),
      .flip   (flips[g])
    );
  end

  mcbd_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .acc        (acc),
    .stable_cur (cur_stable),
    .flips      (flips),
    .stable_next(stable_next),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .changed    (changed),
    .stable_byte(stable_byte)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        stable_q[i] <= '0;
      end
    end else if (acc && ch_ok) begin
      stable_q[ch_idx] <= stable_next;
    end
  end

  a_unimpl_zero: assert property (@(posedge clk) disable iff (rst)
    acc && !ch_ok |=> out_valid && !changed && (stable_byte == '0))
    else $error("unimplemented channel gave a nonzero result");

  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    acc && ch_ok |=> out_valid && (stable_byte == stable_q[$past(ch_idx)]))
    else $error("result byte differs from stored stable byte");

  a_changed_consistent: assert property (@(posedge clk) disable iff (rst)
    acc && ch_ok |=> changed == (stable_byte != $past(cur_stable)))
    else $error("changed flag disagrees with stable byte update");

  a_sensor_low_clear: assert property (@(posedge clk) disable iff (rst)
    stable_q[CH_SENSOR][3:0] == 4'h0)
    else $error("sensor low nibble became set");

endmodule

>>> rtl/mcbd_lane.sv
// ----------------------------------------------------------------------------
// mcbd_lane
// Debounce counters of one bit position, one counter per channel.
// ----------------------------------------------------------------------------
module mcbd_lane
  import mcbd_pkg::*;
#(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic [$clog2(NUM_CHANNELS)-1:0] ch_idx,
  input  lane_in_t                        lane_in,
  output logic                            flip
);

  logic [CNT_W-1:0] counts [NUM_CHANNELS];
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_inc;
  logic             differ;
  logic             hit;
  logic [CNT_W-1:0] cnt_next;

  always_comb begin
    cnt      = counts[ch_idx];
    differ   = lane_in.new_bit ^ lane_in.stable_bit;
    cnt_inc  = (cnt == CNT_MAX) ? cnt : cnt + 1'b1;
    hit      = differ && (cnt_inc >= lane_in.limit);
    cnt_next = (differ && !hit) ? cnt_inc : '0;
    flip     = lane_in.en && hit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        counts[i] <= '0;
      end
    end else if (lane_in.en) begin
      counts[ch_idx] <= cnt_next;
    end
  end

endmodule

>>> rtl/mcbd_merge.sv
// ----------------------------------------------------------------------------
// mcbd_merge
// Combines the lane flips into the new stable byte and holds the result beat.
// ----------------------------------------------------------------------------
module mcbd_merge
  import mcbd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   acc,
  input  logic [BITS_PER_CH-1:0] stable_cur,
  input  logic [BITS_PER_CH-1:0] flips,
  output logic [BITS_PER_CH-1:0] stable_next,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   changed,
  output logic [BITS_PER_CH-1:0] stable_byte
);

  assign stable_next = stable_cur ^ flips;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      changed     <= |flips;
      stable_byte <= stable_next;
    end
  end

endmodule
